@@ design/trie_prefix_counter_assert.svh @@
// Assertion macros used by the trie prefix counter RTL (included by tpc_walk).
`ifndef TRIE_PREFIX_COUNTER_ASSERT_SVH
`define TRIE_PREFIX_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpc assertion failed");

`endif

@@ design/tpc_pkg.sv @@
`default_nettype none

package tpc_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 26;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int LETTER_W   = 5;
  localparam int COUNT_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_FIN   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } child_port_t;

  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  waddr;
    logic [COUNT_W-1:0] wdata;
    logic [NODE_W-1:0]  raddr;
  } cnt_port_t;

endpackage

`default_nettype wire

@@ design/tpc_if.sv @@
`default_nettype none

interface tpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [tpc_pkg::LETTER_W-1:0]  letter;
  logic                          last;

  modport source (output valid, output op, output letter, output last, input ready);
  modport sink   (input valid, input op, input letter, input last, output ready);
endinterface

interface tpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tpc_pkg::COUNT_W-1:0]   prefix_count;
  logic                          table_full;

  modport source (output valid, output prefix_count, output table_full, input ready);
  modport sink   (input valid, input prefix_count, input table_full, output ready);
endinterface

`default_nettype wire

@@ design/tpc_ram.sv @@
`default_nettype none

module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/tpc_walk.sv @@
`default_nettype none

`include "trie_prefix_counter_assert.svh"

module tpc_walk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tpc_in_if.sink                             in_chan,
  tpc_out_if.source                          out_chan,
  output tpc_pkg::child_port_t               child_port,
  input  wire logic [tpc_pkg::NODE_W-1:0]    child_q,
  output tpc_pkg::cnt_port_t                 cnt_port,
  input  wire logic [tpc_pkg::COUNT_W-1:0]   cnt_q
);

  tpc_pkg::state_t state_r, state_nxt;

  logic [tpc_pkg::SLOT_W-1:0]  clr_r, clr_nxt;
  logic [tpc_pkg::NODE_W-1:0]  cursor_r, cursor_nxt;
  logic [tpc_pkg::USED_W-1:0]  used_r, used_nxt;
  logic                        missing_r, missing_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        op_r, op_nxt;
  logic                        letter_ok_r, letter_ok_nxt;
  logic                        last_r, last_nxt;
  logic [tpc_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [tpc_pkg::NODE_W-1:0]  fin_node_r, fin_node_nxt;
  logic                        fin_op_r, fin_op_nxt;
  logic [tpc_pkg::COUNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                        res_full_r, res_full_nxt;
  logic [tpc_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                        out_full_r, out_full_nxt;

  logic                          in_ok, out_free, in_letter_ok;
  logic [tpc_pkg::LETTER_W-1:0]  letter_c;
  logic [tpc_pkg::SLOT_W-1:0]    slot_in;
  logic [tpc_pkg::USED_W-1:0]    used_inc;
  logic                          ins_act, child_zero, can_alloc, alloc, ovf_hit;
  logic                          qry_act, qry_break, ovf_n, miss_n, need_fin;
  logic [tpc_pkg::NODE_W-1:0]    new_child, cur_n;
  logic [tpc_pkg::COUNT_W-1:0]   cnt_inc, fin_inc;
  logic                          deliver;
  logic [tpc_pkg::COUNT_W-1:0]   dl_cnt;
  logic                          dl_full;

  assign in_chan.ready         = (state_r == tpc_pkg::S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.prefix_count = out_cnt_r;
  assign out_chan.table_full   = out_full_r;

  assign in_ok        = in_chan.valid && in_chan.ready;
  assign out_free     = !out_valid_r || out_chan.ready;
  assign in_letter_ok = (32'(in_chan.letter) < tpc_pkg::ALPHABET_SIZE);
  assign letter_c     = in_letter_ok ? in_chan.letter : '0;
  assign slot_in      = tpc_pkg::SLOT_W'(cursor_r) * tpc_pkg::SLOT_W'(tpc_pkg::ALPHABET_SIZE)
                      + tpc_pkg::SLOT_W'(letter_c);

  // Execute-cycle decisions from the registered memory reads.
  assign used_inc   = used_r + tpc_pkg::USED_W'(1);
  assign child_zero = (child_q == '0);
  assign can_alloc  = (32'(used_inc) < tpc_pkg::NODE_COUNT);
  assign ins_act    = (op_r == tpc_pkg::OP_INSERT) && !ovf_r && letter_ok_r;
  assign alloc      = ins_act && child_zero && can_alloc;
  assign ovf_hit    = ins_act && child_zero && !can_alloc;
  assign new_child  = alloc ? used_inc[tpc_pkg::NODE_W-1:0] : child_q;
  assign qry_act    = (op_r == tpc_pkg::OP_QUERY) && !missing_r;
  assign qry_break  = qry_act && (!letter_ok_r || child_zero);
  assign ovf_n      = ovf_r | ovf_hit;
  assign miss_n     = missing_r | qry_break;
  assign need_fin   = last_r && ((op_r == tpc_pkg::OP_INSERT) ? !ovf_n : !miss_n);
  assign cnt_inc    = (cnt_q == tpc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign fin_inc    = cnt_inc;

  always_comb begin
    if (ins_act && !ovf_hit) begin
      cur_n = new_child;
    end else if (qry_act && !qry_break) begin
      cur_n = child_q;
    end else begin
      cur_n = cursor_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cursor_nxt    = cursor_r;
    used_nxt      = used_r;
    missing_nxt   = missing_r;
    ovf_nxt       = ovf_r;
    op_nxt        = op_r;
    letter_ok_nxt = letter_ok_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    fin_node_nxt  = fin_node_r;
    fin_op_nxt    = fin_op_r;
    res_cnt_nxt   = res_cnt_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_cnt_nxt   = out_cnt_r;
    out_full_nxt  = out_full_r;
    deliver       = 1'b0;
    dl_cnt        = '0;
    dl_full       = 1'b0;

    child_port.we    = 1'b0;
    child_port.waddr = slot_r;
    child_port.wdata = '0;
    child_port.raddr = slot_in;
    cnt_port.we      = 1'b0;
    cnt_port.waddr   = cursor_r;
    cnt_port.wdata   = cnt_inc;
    cnt_port.raddr   = cursor_r;

    unique case (state_r)
      tpc_pkg::S_CLEAR: begin
        child_port.we    = 1'b1;
        child_port.waddr = clr_r;
        cnt_port.we      = (clr_r < tpc_pkg::SLOT_W'(tpc_pkg::NODE_COUNT));
        cnt_port.waddr   = clr_r[tpc_pkg::NODE_W-1:0];
        cnt_port.wdata   = '0;
        clr_nxt          = clr_r + 1'b1;
        if (clr_r == tpc_pkg::SLOT_W'(tpc_pkg::SLOT_DEPTH - 1)) begin
          state_nxt = tpc_pkg::S_IDLE;
        end
      end
      tpc_pkg::S_IDLE: begin
        if (in_ok) begin
          op_nxt        = in_chan.op;
          letter_ok_nxt = in_letter_ok;
          last_nxt      = in_chan.last;
          slot_nxt      = slot_in;
          state_nxt     = tpc_pkg::S_EXEC;
        end
      end
      tpc_pkg::S_EXEC: begin
        // Bump the node we leave; link a fresh child if the slot was empty and a node is free.
        if (ins_act && !ovf_hit) begin
          cnt_port.we    = 1'b1;
          cnt_port.waddr = cursor_r;
          cnt_port.wdata = cnt_inc;
        end
        if (alloc) begin
          child_port.we    = 1'b1;
          child_port.waddr = slot_r;
          child_port.wdata = used_inc[tpc_pkg::NODE_W-1:0];
          used_nxt         = used_inc;
        end
        cnt_port.raddr = cur_n;
        if (!last_r) begin
          cursor_nxt  = cur_n;
          missing_nxt = miss_n;
          ovf_nxt     = ovf_n;
          state_nxt   = tpc_pkg::S_IDLE;
        end else begin
          cursor_nxt  = '0;
          missing_nxt = 1'b0;
          ovf_nxt     = 1'b0;
          if (need_fin) begin
            fin_node_nxt = cur_n;
            fin_op_nxt   = op_r;
            state_nxt    = tpc_pkg::S_FIN;
          end else begin
            deliver = 1'b1;
            dl_cnt  = '0;
            dl_full = (op_r == tpc_pkg::OP_INSERT) && ovf_n;
          end
        end
      end
      tpc_pkg::S_FIN: begin
        if (fin_op_r == tpc_pkg::OP_INSERT) begin
          cnt_port.we    = 1'b1;
          cnt_port.waddr = fin_node_r;
          cnt_port.wdata = fin_inc;
          dl_cnt         = '0;
        end else begin
          dl_cnt = cnt_q;
        end
        deliver = 1'b1;
        dl_full = 1'b0;
      end
      tpc_pkg::S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = res_cnt_r;
          out_full_nxt  = res_full_r;
          state_nxt     = tpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tpc_pkg::S_IDLE;
      end
    endcase

    // Load the output word when the slot frees up, else park it.
    if (deliver) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = dl_cnt;
        out_full_nxt  = dl_full;
        state_nxt     = tpc_pkg::S_IDLE;
      end else begin
        res_cnt_nxt  = dl_cnt;
        res_full_nxt = dl_full;
        state_nxt    = tpc_pkg::S_PUSH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpc_pkg::S_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      used_r      <= '0;
      missing_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      missing_r   <= missing_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    letter_ok_r <= letter_ok_nxt;
    last_r      <= last_nxt;
    slot_r      <= slot_nxt;
    fin_node_r  <= fin_node_nxt;
    fin_op_r    <= fin_op_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_full_r  <= res_full_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_full_r  <= out_full_nxt;
  end

  `TPC_ASSERT_NXT(a_accept_exec, clk, rst_n, in_ok, state_r == tpc_pkg::S_EXEC)
  `TPC_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, 32'(used_r) < tpc_pkg::NODE_COUNT)
  `TPC_ASSERT_IMP(a_link_nonzero, clk, rst_n, (state_r == tpc_pkg::S_EXEC) && child_port.we,
                  child_port.wdata != '0)
  `TPC_ASSERT_IMP(a_push_full, clk, rst_n, state_r == tpc_pkg::S_PUSH, out_valid_r)

endmodule

`default_nettype wire

@@ design/trie_prefix_counter.sv @@
`default_nettype none

// Trie prefix counter: stores lower-case words in an array trie and answers
// how many stored words start with a given prefix. Each input word carries
// one letter with an op (insert or query) and a last mark; a result word is
// emitted only for a letter marked last. Inserts report table_full when the
// node table ran out (the rest of that word is dropped), queries report the
// prefix count or zero when the path breaks. Counts saturate at all ones.
// Steps: a letter is accepted with its child-table read, then executed
// with write-back, since the child table has a registered read; a last
// letter that reaches a node adds a final step, since the final node's
// count needs its own read of the count memory. After reset the block
// clears all NODE_COUNT*ALPHABET_SIZE child-table entries (106496 by
// default) and the count table, and takes no input word until it is done.

module trie_prefix_counter (
  input wire logic   clk,
  input wire logic   rst_n,
  tpc_in_if.sink     in_chan,
  tpc_out_if.source  out_chan
);

  tpc_pkg::child_port_t          child_port;
  tpc_pkg::cnt_port_t            cnt_port;
  logic [tpc_pkg::NODE_W-1:0]    child_q;
  logic [tpc_pkg::COUNT_W-1:0]   cnt_q;

  // Walk control: cursor, allocation, flags and the output register.
  tpc_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .child_port (child_port),
    .child_q    (child_q),
    .cnt_port   (cnt_port),
    .cnt_q      (cnt_q)
  );

  // Child table: one entry per node and letter, zero means no child.
  tpc_ram #(
    .WIDTH (tpc_pkg::NODE_W),
    .DEPTH (tpc_pkg::SLOT_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_port.we),
    .waddr (child_port.waddr),
    .wdata (child_port.wdata),
    .raddr (child_port.raddr),
    .rdata (child_q)
  );

  // Prefix counts: words passing through each node.
  tpc_ram #(
    .WIDTH (tpc_pkg::COUNT_W),
    .DEPTH (tpc_pkg::NODE_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_port.we),
    .waddr (cnt_port.waddr),
    .wdata (cnt_port.wdata),
    .raddr (cnt_port.raddr),
    .rdata (cnt_q)
  );

endmodule

`default_nettype wire
